### rtl/chbd_pkg.sv
`timescale 1ns / 1ps

package chbd_pkg;

    // size line limits and field widths
    localparam int DEFAULT_MAX_SIZE_DIGITS = 15;
    localparam int DIGIT_W = 5;
    localparam int COUNT_W = 60;
    localparam int HEX_W   = 4;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_AFTER_DATA,
        PH_AFTER_CR,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        OC_ONGOING,
        OC_TERMINATED,
        OC_MALFORMED,
        OC_TRUNCATED
    } outcome_t;

    typedef struct packed {
        phase_t               phase;
        logic [DIGIT_W-1:0]   digit_count;
        logic [COUNT_W-1:0]   chunk_count;
        logic                 extension_seen;
    } dec_state_t;

    typedef struct packed {
        dec_state_t state;
        outcome_t   outcome;
    } line_step_t;

    typedef struct packed {
        outcome_t   outcome;
        logic       end_of_body;
        logic       has_byte;
        logic [7:0] out_byte;
    } chbd_result_t;

    localparam dec_state_t LINE_START = '{
        phase:          PH_SIZE,
        digit_count:    '0,
        chunk_count:    '0,
        extension_seen: 1'b0
    };

    // returns {is_hex, nibble}
    function automatic logic [HEX_W:0] hex_decode(input logic [7:0] c);
        logic [HEX_W:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, HEX_W'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, HEX_W'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, HEX_W'(c - 8'h37)};
        end
        return r;
    endfunction

    // one byte of a size line
    function automatic line_step_t size_line_byte(
        input dec_state_t         s,
        input logic [7:0]         c,
        input logic [DIGIT_W-1:0] limit
    );
        line_step_t     r;
        logic [HEX_W:0] hx;
        r.state   = s;
        r.outcome = OC_ONGOING;
        hx        = hex_decode(c);
        if (c == CHAR_LF) begin
            if (s.digit_count == '0 || s.digit_count > limit) begin
                r.state.phase = PH_DONE;
                r.outcome     = OC_MALFORMED;
            end else if (s.chunk_count == '0) begin
                r.state.phase = PH_DONE;
                r.outcome     = OC_TERMINATED;
            end else begin
                r.state.phase          = PH_DATA;
                r.state.digit_count    = '0;
                r.state.extension_seen = 1'b0;
            end
        end else if (!s.extension_seen) begin
            if (!hx[HEX_W]) begin
                r.state.extension_seen = 1'b1;
            end else if (s.digit_count <= limit) begin
                r.state.digit_count = s.digit_count + 1'b1;
                // the first digit past the limit is counted but not accumulated; later digits are ignored
                if (s.digit_count < limit) begin
                    r.state.chunk_count = {s.chunk_count[COUNT_W-HEX_W-1:0], hx[HEX_W-1:0]};
                end
            end
        end
        return r;
    endfunction

endpackage

### rtl/http_chunked_body_decoder.sv
`timescale 1ns / 1ps

// HTTP chunked body decoder. Raw body bytes enter one word per clock while
// the skid stage is empty, and the chunk framing is stripped: data bytes leave
// with m_tuser[0] set, and the word that ends a body carries m_tlast with the
// outcome in m_tuser[2:1] (terminated by a zero chunk, malformed size line, or
// input ended early). Size lines, CR/LF and anything after the end produce no
// output word. A single decode step lies between the state register and the
// output register. A one-word skid stage behind the output register lets
// input continue while a result waits; s_tready drops while it is full.
// s_tlast marks the last byte of a body and returns the decoder to its reset
// state.

module http_chunked_body_decoder
    import chbd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = DEFAULT_MAX_SIZE_DIGITS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [2:0] m_tuser,   // has_byte, outcome[1:0]
    output logic       m_tlast    // end_of_body
);

    logic         accept;
    logic         res_valid;
    chbd_result_t res;

    logic         out_valid_reg, out_valid_next;
    chbd_result_t out_reg, out_next;
    logic         skid_valid_reg, skid_valid_next;
    chbd_result_t skid_reg, skid_next;
    logic         drain;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    chbd_core #(
        .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register with skid stage
    always_comb begin
        drain           = !out_valid_reg || m_tready;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (drain) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tuser  = {out_reg.outcome, out_reg.has_byte};
    assign m_tlast  = out_reg.end_of_body;

    // skid stage only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    // a word without a data byte always closes a body
    a_no_byte_ends_body: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("empty result word does not end the body");

    // outcome is reported exactly on the closing word
    a_outcome_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[2:1] != OC_ONGOING)))
        else $error("outcome and end of body disagree");

endmodule

### rtl/chbd_core.sv
`timescale 1ns / 1ps

module chbd_core
    import chbd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = DEFAULT_MAX_SIZE_DIGITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  logic [7:0]   in_byte,
    input  logic         in_last,
    output logic         res_valid,
    output chbd_result_t res
);

    localparam logic [DIGIT_W-1:0] DigitLimit = DIGIT_W'(MAX_SIZE_DIGITS);

    dec_state_t state_reg, state_next;
    dec_state_t step_state;
    line_step_t line_res;
    outcome_t   oc;
    logic       has;
    logic       was_done;
    logic [COUNT_W-1:0] count_dec;

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LINE_START;
        end else if (in_valid) begin
            state_reg <= state_next;
        end
    end

    // per-word step and result
    always_comb begin
        step_state = state_reg;
        oc         = OC_ONGOING;
        has        = 1'b0;
        was_done   = (state_reg.phase == PH_DONE);
        count_dec  = state_reg.chunk_count - 1'b1;
        line_res   = size_line_byte(LINE_START, in_byte, DigitLimit);

        unique case (state_reg.phase)
            PH_SIZE: begin
                line_res   = size_line_byte(state_reg, in_byte, DigitLimit);
                step_state = line_res.state;
                oc         = line_res.outcome;
            end
            PH_DATA: begin
                has                    = 1'b1;
                step_state.chunk_count = count_dec;
                if (count_dec == '0) begin
                    step_state.phase = PH_AFTER_DATA;
                end
            end
            PH_AFTER_DATA: begin
                if (in_byte == CHAR_CR) begin
                    step_state.phase = PH_AFTER_CR;
                end else if (in_byte == CHAR_LF) begin
                    step_state = LINE_START;
                end else begin
                    step_state = line_res.state;
                    oc         = line_res.outcome;
                end
            end
            PH_AFTER_CR: begin
                if (in_byte == CHAR_LF) begin
                    step_state = LINE_START;
                end else begin
                    step_state = line_res.state;
                    oc         = line_res.outcome;
                end
            end
            default: begin
                step_state.phase = PH_DONE;
            end
        endcase

        // last word of the body rearms for the next one
        state_next = in_last ? LINE_START : step_state;

        res.out_byte    = has ? in_byte : 8'h00;
        res.has_byte    = has;
        res.end_of_body = 1'b0;
        res.outcome     = OC_ONGOING;
        if (oc != OC_ONGOING) begin
            res.end_of_body = 1'b1;
            res.outcome     = oc;
        end else if (in_last && !was_done) begin
            res.end_of_body = 1'b1;
            res.outcome     = OC_TRUNCATED;
        end
        res_valid = in_valid && (has || res.end_of_body);
    end

endmodule

### bench/http_chunked_body_decoder_test.sv
`timescale 1ns / 1ps

module http_chunked_body_decoder_test;
    import chbd_pkg::*;

    localparam int SIZE_DIGITS  = DEFAULT_MAX_SIZE_DIGITS;
    localparam int RANDOM_WORDS = 1100;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int N_DIRECTED   = 27;

    // one row of the directed table; pinned rows carry a hand-typed result
    typedef struct packed {
        logic [7:0]   b;
        logic         lst;
        logic         pinned;
        logic         pin_got;
        chbd_result_t pin_res;
    } stim_row_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    // pinned expectation travels with the word it belongs to
    logic         pin_active = 1'b0;
    logic         pin_got    = 1'b0;
    chbd_result_t pin_res    = '0;
    logic         steady     = 1'b0;

    // decoder state as the checker sees it
    phase_t      ph;
    logic [4:0]  digits;
    logic [59:0] remaining;
    logic        in_ext;

    chbd_result_t expected_words[$];
    logic [7:0]   frame_bytes[$];
    stim_row_t    dir_rows [N_DIRECTED];

    int mismatches   = 0;
    int words_sent   = 0;
    int quiet_cycles = 0;
    int n_data       = 0;
    int n_term       = 0;
    int n_malf       = 0;
    int n_trunc      = 0;
    int n_bodies     = 0;

    http_chunked_body_decoder #(
        .MAX_SIZE_DIGITS(SIZE_DIGITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // {is_hex, value}; letters share the low nibble trick for both cases
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b1, c[3:0] + 4'd9};
        return 5'b0;
    endfunction

    function void restart_line();
        ph        = PH_SIZE;
        digits    = '0;
        remaining = '0;
        in_ext    = 1'b0;
    endfunction

    // one byte of a size line, returns the outcome if the body ends here
    function outcome_t size_byte(logic [7:0] c);
        logic [4:0] hx;
        hx = hex_nibble(c);
        if (c == CHAR_LF) begin
            if (digits == 0 || digits > SIZE_DIGITS) begin
                ph = PH_DONE;
                return OC_MALFORMED;
            end
            if (remaining == '0) begin
                ph = PH_DONE;
                return OC_TERMINATED;
            end
            ph     = PH_DATA;
            digits = '0;
            in_ext = 1'b0;
        end else if (!in_ext) begin
            if (!hx[4]) begin
                in_ext = 1'b1;
            end else if (digits <= SIZE_DIGITS) begin
                digits = digits + 1'b1;
                if (digits <= SIZE_DIGITS) remaining = {remaining[55:0], hx[3:0]};
            end
        end
        return OC_ONGOING;
    endfunction

    // advance the decoder by one input word and work out its result, if any
    function void decode_byte(input logic [7:0] c, input logic lst,
                              output logic got, output chbd_result_t r);
        outcome_t oc;
        logic     has;
        logic     was_done;
        oc       = OC_ONGOING;
        has      = 1'b0;
        was_done = (ph == PH_DONE);
        case (ph)
            PH_DATA: begin
                has       = 1'b1;
                remaining = remaining - 1'b1;
                if (remaining == '0) ph = PH_AFTER_DATA;
            end
            PH_AFTER_DATA: begin
                if (c == CHAR_CR) begin
                    ph = PH_AFTER_CR;
                end else begin
                    restart_line();
                    if (c != CHAR_LF) oc = size_byte(c);
                end
            end
            PH_AFTER_CR: begin
                restart_line();
                if (c != CHAR_LF) oc = size_byte(c);
            end
            PH_SIZE: begin
                oc = size_byte(c);
            end
            default: begin
                ph = PH_DONE;
            end
        endcase
        r.out_byte    = has ? c : 8'h00;
        r.has_byte    = has;
        r.end_of_body = 1'b0;
        r.outcome     = OC_ONGOING;
        got           = has;
        if (oc != OC_ONGOING) begin
            r.end_of_body = 1'b1;
            r.outcome     = oc;
            got           = 1'b1;
            if (lst) restart_line();
        end else if (lst) begin
            restart_line();
            if (!was_done) begin
                r.end_of_body = 1'b1;
                r.outcome     = OC_TRUNCATED;
                got           = 1'b1;
            end
        end
    endfunction

    function stim_row_t free_row(logic [7:0] b, logic lst);
        return '{b: b, lst: lst, pinned: 1'b0, pin_got: 1'b0, pin_res: '0};
    endfunction

    function stim_row_t pin_none(logic [7:0] b, logic lst);
        return '{b: b, lst: lst, pinned: 1'b1, pin_got: 1'b0, pin_res: '0};
    endfunction

    function stim_row_t pin_word(logic [7:0] b, logic lst, logic has, logic eob, outcome_t oc);
        chbd_result_t r;
        r.out_byte    = has ? b : 8'h00;
        r.has_byte    = has;
        r.end_of_body = eob;
        r.outcome     = oc;
        return '{b: b, lst: lst, pinned: 1'b1, pin_got: 1'b1, pin_res: r};
    endfunction

    task automatic note_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        mismatches++;
    endtask

    // compare one output word against the oldest expectation
    task automatic check_word();
        chbd_result_t e;
        if (expected_words.size() == 0) begin
            note_mismatch($sformatf("unexpected word data=%h user=%b last=%b",
                                    m_tdata, m_tuser, m_tlast));
            return;
        end
        e = expected_words.pop_front();
        if (m_tdata !== e.out_byte)
            note_mismatch($sformatf("out_byte %h, want %h", m_tdata, e.out_byte));
        if (m_tuser[0] !== e.has_byte)
            note_mismatch($sformatf("has_byte %b, want %b", m_tuser[0], e.has_byte));
        if (m_tlast !== e.end_of_body)
            note_mismatch($sformatf("end_of_body %b, want %b", m_tlast, e.end_of_body));
        if (m_tuser[2:1] !== e.outcome)
            note_mismatch($sformatf("outcome %0d, want %0d", m_tuser[2:1], e.outcome));
        if (e.has_byte) n_data++;
        if (e.end_of_body) begin
            case (e.outcome)
                OC_TERMINATED: n_term++;
                OC_MALFORMED:  n_malf++;
                default:       n_trunc++;
            endcase
        end
    endtask

    // monitor both channels; results first since they belong to older words
    always @(posedge aclk) begin
        logic         got;
        chbd_result_t r;
        if (aresetn) begin
            if (m_tvalid && m_tready) check_word();
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast, got, r);
                if (pin_active) begin
                    got = pin_got;
                    r   = pin_res;
                end
                if (got) expected_words.push_back(r);
            end
        end
    end

    // receiver stalls about 8 percent of the time, never during the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 8);
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("http_chunked_body_decoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one word and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic pin,
                             input logic pgot, input chbd_result_t pres);
        steady <= (words_sent >= 450 && words_sent < 700);
        while (!steady && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tlast    <= lst;
        pin_active <= pin;
        pin_got    <= pgot;
        pin_res    <= pres;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // hold the sender until every expected word has come back
    task automatic drain_pending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    function logic [7:0] hex_char(logic [3:0] n, logic upper);
        if (n < 10) return "0" + n;
        return 8'((upper ? "A" : "a") + n - 10);
    endfunction

    // hex size of at least min_digits digits, random letter case
    function void push_hex(logic [59:0] v, int min_digits);
        int need;
        need = 1;
        while (need < 15 && (v >> (4 * need)) != 0) need++;
        if (min_digits > need) need = min_digits;
        for (int i = need - 1; i >= 0; i--)
            frame_bytes.push_back(hex_char(v[4*i +: 4], $urandom_range(0, 1)));
    endfunction

    function logic [7:0] any_but_lf();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CHAR_LF);
        return b;
    endfunction

    // optional extension text, optional CR, then the line feed
    function void close_size_line();
        if ($urandom_range(0, 9) < 3) begin
            frame_bytes.push_back(";");
            repeat ($urandom_range(0, 4)) frame_bytes.push_back(any_but_lf());
        end
        if ($urandom_range(0, 1)) frame_bytes.push_back(CHAR_CR);
        frame_bytes.push_back(CHAR_LF);
    endfunction

    function void build_good_body();
        int size;
        int width;
        repeat ($urandom_range(1, 3)) begin
            size  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            width = ($urandom_range(0, 9) == 0) ? SIZE_DIGITS : $urandom_range(1, 3);
            push_hex(60'(size), width);
            close_size_line();
            repeat (size) frame_bytes.push_back(8'($urandom));
            case ($urandom_range(0, 3))
                0: begin
                    frame_bytes.push_back(CHAR_CR);
                    frame_bytes.push_back(CHAR_LF);
                end
                1: frame_bytes.push_back(CHAR_CR);
                2: frame_bytes.push_back(CHAR_LF);
                default: ;
            endcase
        end
        push_hex('0, $urandom_range(1, 3));
        close_size_line();
        repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom));
    endfunction

    // random body: mostly well formed, some cut short, oversized, empty or noise
    task automatic send_random_body();
        int         pick;
        int         n;
        int         cut;
        logic [7:0] b;
        frame_bytes.delete();
        pick = $urandom_range(0, 99);
        cut  = 0;
        if (pick < 75) begin
            build_good_body();
            if (pick >= 60) cut = $urandom_range(1, frame_bytes.size());
        end else if (pick < 85) begin
            n = $urandom_range(15, 20);
            if (n == SIZE_DIGITS) begin
                // largest size the counter holds, always cut short
                push_hex(60'hFFF_FFFF_FFFF_FFFF, SIZE_DIGITS);
                frame_bytes.push_back(CHAR_LF);
                repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
            end else begin
                repeat (n) frame_bytes.push_back(hex_char(4'($urandom), $urandom_range(0, 1)));
                close_size_line();
                repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
            end
        end else if (pick < 93) begin
            // size line without digits
            if ($urandom_range(0, 1)) begin
                do b = any_but_lf(); while (hex_nibble(b) != 0);
                frame_bytes.push_back(b);
                repeat ($urandom_range(0, 3)) frame_bytes.push_back(any_but_lf());
            end
            frame_bytes.push_back(CHAR_LF);
            repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
        end
        if (cut == 0) cut = frame_bytes.size();
        for (int i = 0; i < cut; i++)
            send_byte(frame_bytes[i], i == cut - 1, 1'b0, 1'b0, '0);
        n_bodies++;
    endtask

    // stimulus
    initial begin
        restart_line();
        dir_rows = '{
            pin_word(CHAR_LF, 1'b0, 1'b0, 1'b1, OC_MALFORMED),   // empty size line
            pin_none("q", 1'b1),                                 // dropped after end
            free_row("0", 1'b0),
            pin_word(CHAR_LF, 1'b0, 1'b0, 1'b1, OC_TERMINATED),  // zero chunk
            pin_none("t", 1'b1),
            free_row("1", 1'b0),                                 // size with extension
            free_row(";", 1'b0),
            free_row("5", 1'b0),
            free_row(CHAR_LF, 1'b0),
            pin_word(8'h00, 1'b0, 1'b1, 1'b0, OC_ONGOING),
            free_row(CHAR_CR, 1'b0),
            free_row(CHAR_LF, 1'b0),
            free_row("0", 1'b0),                                 // leading zero
            free_row("1", 1'b0),
            free_row(CHAR_LF, 1'b0),
            pin_word(8'hFF, 1'b0, 1'b1, 1'b0, OC_ONGOING),
            free_row("Z", 1'b0),                                 // no CR/LF after data
            pin_word(CHAR_LF, 1'b0, 1'b0, 1'b1, OC_MALFORMED),
            pin_none(CHAR_LF, 1'b1),
            free_row("2", 1'b0),                                 // ends inside data
            free_row(CHAR_LF, 1'b0),
            pin_word(8'h41, 1'b1, 1'b1, 1'b1, OC_TRUNCATED),
            pin_word("f", 1'b1, 1'b0, 1'b1, OC_TRUNCATED),       // ends inside size line
            free_row("1", 1'b0),                                 // ends on the optional CR
            free_row(CHAR_LF, 1'b0),
            free_row(CHAR_CR, 1'b0),
            pin_word(CHAR_CR, 1'b1, 1'b0, 1'b1, OC_TRUNCATED)
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].lst, dir_rows[i].pinned,
                      dir_rows[i].pin_got, dir_rows[i].pin_res);
        drain_pending();

        // random bodies
        while (words_sent < N_DIRECTED + RANDOM_WORDS) begin
            send_random_body();
            if ($urandom_range(0, 19) == 0) drain_pending();
        end
        s_tvalid <= 1'b0;

        // let the pipeline empty out
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d input words in %0d random bodies plus a directed table",
                 words_sent, n_bodies);
        $display("checked %0d data words, bodies terminated %0d, malformed %0d, truncated %0d",
                 n_data, n_term, n_malf, n_trunc);
        if (mismatches == 0) begin
            $display("http_chunked_body_decoder verification clean");
        end else begin
            $display("http_chunked_body_decoder verification failed");
        end
        $finish;
    end

endmodule
